FILE: rtl/core/fwsr_pkg.sv
// ----------------------------------------------------------------------------
// fwsr_pkg
// Shared types and codes for the ordered page queue with search and remove.
// ----------------------------------------------------------------------------
`default_nettype none

package fwsr_pkg;

  // operation codes carried by an input beat
  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_OVFL = 2'd2
  } status_e;

  localparam int unsigned ValueW = 31;
  localparam int unsigned CountW = 5;

  // input beat
  typedef struct packed {
    op_e                opcode;
    logic [ValueW-1:0]  value;
  } in_t;

  // result beat
  typedef struct packed {
    logic               found;
    logic [ValueW-1:0]  removed_value;
    logic               is_empty;
    logic               is_full;
    logic [CountW-1:0]  entry_count;
    status_e            status;
  } out_t;

  // top level to engine
  typedef struct packed {
    logic start;
    logic take;
    in_t  item;
  } req_t;

  // engine to top level
  typedef struct packed {
    logic idle;
    logic done;
    out_t res;
  } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/fwsr_engine.sv
// ----------------------------------------------------------------------------
// fwsr_engine
// Entry store and sequencer: one shared read port and comparator walk the
// entries in order for search, then the same port closes the gap on removal.
// ----------------------------------------------------------------------------
`default_nettype none

module fwsr_engine #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire fwsr_pkg::req_t req_i,
  output fwsr_pkg::rsp_t     rsp_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_RESP   = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  logic [CW-1:0]                   occ_q, occ_d;
  logic [CW-1:0]                   rd_ptr_q, rd_ptr_d;
  logic                            rd_vld_q, rd_vld_d;
  logic [IW-1:0]                   cmp_idx_q, cmp_idx_d;
  fwsr_pkg::op_e                   op_q, op_d;
  logic [fwsr_pkg::ValueW-1:0]     val_q, val_d;
  logic                            found_q, found_d;
  logic [fwsr_pkg::ValueW-1:0]     removed_q, removed_d;
  fwsr_pkg::status_e               status_q, status_d;

  logic [fwsr_pkg::ValueW-1:0]     mem_q [DEPTH];
  logic [fwsr_pkg::ValueW-1:0]     rd_data_q;
  logic                            mem_we;
  logic [IW-1:0]                   mem_waddr;
  logic [fwsr_pkg::ValueW-1:0]     mem_wdata;
  logic                            rd_en;
  logic                            hit;
  logic                            last;

  // compare of the entry read last cycle; dequeue matches the head
  assign hit  = rd_vld_q && ((op_q == fwsr_pkg::OP_DEQ) || (rd_data_q == val_q));
  // walk finished: nothing in flight and no entry left to read
  assign last = !rd_vld_q && (rd_ptr_q >= occ_q);

  // sequencer
  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    rd_ptr_d  = rd_ptr_q;
    rd_vld_d  = 1'b0;
    cmp_idx_d = cmp_idx_q;
    op_d      = op_q;
    val_d     = val_q;
    found_d   = found_q;
    removed_d = removed_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rd_data_q;
    rd_en     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          op_d      = req_i.item.opcode;
          val_d     = req_i.item.value;
          found_d   = 1'b0;
          removed_d = '0;
          status_d  = fwsr_pkg::STAT_OK;
          rd_ptr_d  = '0;
          case (req_i.item.opcode)
            fwsr_pkg::OP_ENQ: begin
              if (occ_q >= DepthC) begin
                status_d = fwsr_pkg::STAT_OVFL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = occ_q[IW-1:0];
                mem_wdata = req_i.item.value;
                occ_d     = occ_q + CW'(1);
              end
              state_d = S_RESP;
            end
            fwsr_pkg::OP_DEQ: begin
              if (occ_q == '0) begin
                status_d = fwsr_pkg::STAT_MISS;
                state_d  = S_RESP;
              end else begin
                state_d = S_SEARCH;
              end
            end
            default: begin
              state_d = S_SEARCH;
            end
          endcase
        end
      end

      S_SEARCH: begin
        // issue the next read, one entry per cycle
        if (rd_ptr_q < occ_q) begin
          rd_en     = 1'b1;
          rd_vld_d  = 1'b1;
          cmp_idx_d = rd_ptr_q[IW-1:0];
          rd_ptr_d  = rd_ptr_q + CW'(1);
        end
        if (hit) begin
          found_d = (op_q != fwsr_pkg::OP_DEQ);
          if (op_q == fwsr_pkg::OP_QUERY) begin
            state_d = S_RESP;
          end else begin
            removed_d = rd_data_q;
            state_d   = S_SHIFT;
          end
        end else if (last) begin
          status_d = fwsr_pkg::STAT_MISS;
          state_d  = S_RESP;
        end
      end

      S_SHIFT: begin
        // read entry i+1 while entry i-1 takes the one read last cycle
        if (rd_ptr_q < occ_q) begin
          rd_en     = 1'b1;
          rd_vld_d  = 1'b1;
          cmp_idx_d = rd_ptr_q[IW-1:0];
          rd_ptr_d  = rd_ptr_q + CW'(1);
        end
        if (rd_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = cmp_idx_q - IW'(1);
          mem_wdata = rd_data_q;
        end
        if (last) begin
          occ_d   = occ_q - CW'(1);
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (req_i.take) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      occ_q    <= '0;
      rd_ptr_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      rd_ptr_q <= rd_ptr_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  // operation and result registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    op_q      <= op_d;
    val_q     <= val_d;
    found_q   <= found_d;
    removed_q <= removed_d;
    status_q  <= status_d;
  end

  // entry store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_ptr_q[IW-1:0]];
    end
  end

  // response
  always_comb begin
    rsp_o.idle              = (state_q == S_IDLE);
    rsp_o.done              = (state_q == S_RESP);
    rsp_o.res.found         = found_q;
    rsp_o.res.removed_value = removed_q;
    rsp_o.res.is_empty      = (occ_q == '0);
    rsp_o.res.is_full       = (occ_q >= DepthC);
    rsp_o.res.entry_count   = fwsr_pkg::CountW'(occ_q);
    rsp_o.res.status        = status_q;
  end

endmodule

`default_nettype wire

FILE: rtl/core/fifo_with_search_and_remove_top.sv
// ----------------------------------------------------------------------------
// fifo_with_search_and_remove_top
// Bounded ordered page queue: enqueue, dequeue, remove by value, query.
// ----------------------------------------------------------------------------
// One input beat gives one result beat. The entries sit in a one-port-read,
// one-port-write store that is walked one entry per cycle, so the time an
// item takes follows the occupancy N: enqueue, and dequeue on an empty queue,
// give their result without a walk; query walks to a match at position i, or
// past all N entries on a miss; dequeue and remove search to the match and
// then close the gap with the same read port (query and remove on an empty
// queue find nothing to read and miss). One item is processed at a time; the
// next beat is taken once the result has entered the output register. A new
// beat is taken while a finished result still waits at the output register,
// but a second finished result holds the engine until that register drains.
// Enqueue on a full queue is dropped with overflow status.
`default_nettype none

module fifo_with_search_and_remove_top #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  input  wire fwsr_pkg::in_t  in_data_i,
  output      logic           out_valid_o,
  input  wire logic           out_ready_i,
  output fwsr_pkg::out_t      out_data_o
);

  fwsr_pkg::req_t  req;
  fwsr_pkg::rsp_t  rsp;
  logic            out_valid_q;
  fwsr_pkg::out_t  out_data_q;
  logic            load;

  // result moves out when the output register is free or being drained
  assign load = rsp.done && (!out_valid_q || out_ready_i);

  assign in_ready_o = rsp.idle;

  always_comb begin
    req.start = in_valid_i && rsp.idle;
    req.take  = load;
    req.item  = in_data_i;
  end

  fwsr_engine #(
    .DEPTH (DEPTH)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= rsp.res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // an accepted beat keeps the engine busy for at least the next cycle
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("engine ready right after accepting a beat");

  // an empty queue reports a zero count
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.is_empty) |-> (out_data_o.entry_count == '0))
    else $error("empty flag with nonzero count");

  // overflow is only reported on a full queue
  a_ovfl_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == fwsr_pkg::STAT_OVFL)) |-> out_data_o.is_full)
    else $error("overflow status while not full");

  // a match always carries ok status
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.found) |-> (out_data_o.status == fwsr_pkg::STAT_OK))
    else $error("found with non-ok status");

endmodule

`default_nettype wire
